// File: rtl/core/sfb_pkg.sv
package sfb_pkg;

    // Sync header bytes that open every frame.
    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    // Default frame buffer size in bytes, and the width that holds any frame length.
    localparam int FRAME_BUFFER_BYTES_DEF = 256;
    localparam int FRAME_BYTES_W          = 11;

    // Sync, header and checksum bytes that surround the payload of a frame.
    localparam logic [FRAME_BYTES_W-1:0] FRAME_OVERHEAD = FRAME_BYTES_W'(5);

    // Default depth of the command queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 4;

    // One classified request, handed from the front to the back.
    typedef struct packed {
        logic        header;   // emit sync, sequence number and count first
        logic [7:0]  seq;      // sequence number for the header
        logic [7:0]  count;    // sample count for the header
        logic [15:0] sample;   // sample to emit, low byte first
        logic        trailer;  // emit the checksum after the sample
    } cmd_t;

endpackage

// File: rtl/core/sfb_front.sv
module sfb_front
    import sfb_pkg::*;
#(
    parameter int FRAME_BUFFER_BYTES = FRAME_BUFFER_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [15:0] sample,
    input  logic [7:0]  frame_count,
    output logic        push,
    output cmd_t        push_cmd
);

    localparam logic [FRAME_BYTES_W-1:0] BufferBytes = FRAME_BYTES_W'(FRAME_BUFFER_BYTES);

    logic [7:0] samples_left_reg, samples_left_next;
    logic       dropping_reg, dropping_next;
    logic [7:0] seq_reg, seq_next;

    logic                     starts_frame;
    logic [FRAME_BYTES_W-1:0] frame_bytes;
    logic                     oversize;

    // Frame length for the oversize check: header, two bytes a sample, checksum.
    assign frame_bytes  = {{(FRAME_BYTES_W-9){1'b0}}, frame_count, 1'b0} + FRAME_OVERHEAD;
    assign oversize     = frame_bytes > BufferBytes;
    assign starts_frame = samples_left_reg == 8'd0;

    // Classify each accepted request and track the frame position.
    always_comb
    begin
        samples_left_next = samples_left_reg;
        dropping_next     = dropping_reg;
        seq_next          = seq_reg;
        push              = 1'b0;
        push_cmd.header   = starts_frame;
        push_cmd.seq      = seq_reg;
        push_cmd.count    = frame_count;
        push_cmd.sample   = sample;
        push_cmd.trailer  = 1'b0;
        if (accept)
        begin
            if (starts_frame)
            begin
                if (frame_count != 8'd0)
                begin
                    samples_left_next = frame_count - 8'd1;
                    if (oversize)
                    begin
                        dropping_next = frame_count != 8'd1;
                    end
                    else
                    begin
                        dropping_next    = 1'b0;
                        push             = 1'b1;
                        push_cmd.trailer = frame_count == 8'd1;
                    end
                end
            end
            else
            begin
                samples_left_next = samples_left_reg - 8'd1;
                if (dropping_reg)
                begin
                    dropping_next = samples_left_reg != 8'd1;
                end
                else
                begin
                    push             = 1'b1;
                    push_cmd.trailer = samples_left_reg == 8'd1;
                end
            end
            if (push && push_cmd.trailer)
            begin
                seq_next = seq_reg + 8'd1;
            end
        end
    end

    // Frame tracking state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_left_reg <= 8'd0;
            dropping_reg     <= 1'b0;
            seq_reg          <= 8'd0;
        end
        else
        begin
            samples_left_reg <= samples_left_next;
            dropping_reg     <= dropping_next;
            seq_reg          <= seq_next;
        end
    end

endmodule

// File: rtl/core/sfb_queue.sv
module sfb_queue
    import sfb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int AddrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CountW = $clog2(DEPTH + 1);

    cmd_t              entry_reg [DEPTH];
    logic [AddrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AddrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CountW-1:0] fill_reg, fill_next;

    logic do_push;
    logic do_pop;

    assign full       = fill_reg == CountW'(DEPTH);
    assign head_valid = fill_reg != '0;
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count updates, with wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AddrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AddrW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AddrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AddrW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CountW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CountW'(1);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage; payload only, no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/core/sfb_back.sv
module sfb_back
    import sfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cmd_t       head_cmd,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // tx_byte [7:0]
    output logic       m_tuser,   // frame_end
    output logic       m_tlast    // run_last
);

    // Byte positions within the bytes that one request can cause.
    typedef enum logic [2:0] {
        STEP_SYNC1,
        STEP_SYNC2,
        STEP_SEQ,
        STEP_CNT,
        STEP_LO,
        STEP_HI,
        STEP_CHK
    } step_t;

    step_t      step_reg, step_next;
    logic       busy_reg, busy_next;
    cmd_t       cmd_reg, cmd_next;
    logic [7:0] chk_reg, chk_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_end_reg, out_end_next;
    logic       out_last_reg, out_last_next;

    logic       emit_ok;
    logic       is_last;
    logic [7:0] cur_byte;

    assign emit_ok = !out_valid_reg || m_tready;
    assign is_last = cmd_reg.trailer ? (step_reg == STEP_CHK) : (step_reg == STEP_HI);

    // Byte for the current position.
    always_comb
    begin
        case (step_reg)
            STEP_SYNC1: cur_byte = SYNC_FIRST;
            STEP_SYNC2: cur_byte = SYNC_SECOND;
            STEP_SEQ:   cur_byte = cmd_reg.seq;
            STEP_CNT:   cur_byte = cmd_reg.count;
            STEP_LO:    cur_byte = cmd_reg.sample[7:0];
            STEP_HI:    cur_byte = cmd_reg.sample[15:8];
            STEP_CHK:   cur_byte = chk_reg;
            default:    cur_byte = 8'd0;
        endcase
    end

    // Sequencer: one byte a cycle into the output register while it is free or draining, next
    // request loaded on the last byte of the current one.
    always_comb
    begin
        step_next      = step_reg;
        busy_next      = busy_reg;
        cmd_next       = cmd_reg;
        chk_next       = chk_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_end_next   = out_end_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        if (busy_reg && emit_ok)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_byte;
            out_end_next   = step_reg == STEP_CHK;
            out_last_next  = is_last;
            chk_next       = (step_reg == STEP_SYNC1) ? cur_byte : (chk_reg ^ cur_byte);
            if (is_last)
            begin
                pop       = head_valid;
                busy_next = head_valid;
            end
            else
            begin
                step_next = step_t'(step_reg + 3'd1);
            end
        end
        else if (!busy_reg)
        begin
            pop       = head_valid;
            busy_next = head_valid;
        end
        if (pop)
        begin
            cmd_next  = head_cmd;
            step_next = head_cmd.header ? STEP_SYNC1 : STEP_LO;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_SYNC1;
            busy_reg      <= 1'b0;
            chk_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            busy_reg      <= busy_next;
            chk_reg       <= chk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_byte_reg <= out_byte_next;
        out_end_reg  <= out_end_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_end_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // The checksum byte always closes the bytes of its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_end_reg |-> out_last_reg)
        else $error("checksum byte not marked as last of its request");

    // A request without header never visits the header positions.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !cmd_reg.header |-> step_reg == STEP_LO || step_reg == STEP_HI
            || step_reg == STEP_CHK)
        else $error("header position reached for a sample-only request");

    // The checksum position is only reached by a request that ends a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && step_reg == STEP_CHK |-> cmd_reg.trailer)
        else $error("checksum position without frame end");

    // A byte is only loaded into a free or draining output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_byte_reg))
        else $error("output register overwritten while stalled");
`endif

endmodule

// File: rtl/core/sample_frame_builder.sv
// A request accepted while the block is idle and the output is free passes the queue
// entry, the command register and the output register of the back part to reach m_tdata.
// Throughput: one byte a cycle from the byte sequencer while m_tready does not stall the
// output; a mid-frame sample is 2 bytes, a frame's first 6 (7 if also its last), its last 3.
// Reset (rst_n, asynchronous, active low) clears the queue, the sequencer, the frame
// position and the sequence number; the next request starts a frame.
module sample_frame_builder
    import sfb_pkg::*;
#(
    parameter int FRAME_BUFFER_BYTES = FRAME_BUFFER_BYTES_DEF,
    parameter int QUEUE_DEPTH        = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // sample [15:0], frame_count [23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // tx_byte [7:0]
    output logic        m_tuser,   // frame_end
    output logic        m_tlast    // run_last
);

    logic accept;
    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    // Requests are taken whenever the queue has room, dropped ones included.
    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    // Front: frame tracking and classification.
    sfb_front #(
        .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .sample      (s_tdata[15:0]),
        .frame_count (s_tdata[23:16]),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // Command queue between front and back.
    sfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back: byte sequencer, checksum and output register.
    sfb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
